FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CRP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CRP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crp_pkg.sv
// Types, constants and codes of the CIGAR reference-to-read position walker.
package crp_pkg;

  localparam int COUNT_BITS    = 28;
  localparam int READ_LEN_BITS = 24;
  localparam int REF_POS_BITS  = 31;

  localparam int CNT_EXT_W = COUNT_BITS + 4;
  localparam int READ_W    = 35;
  localparam int REF_W     = 34;
  localparam int IDX_W     = 36;

  localparam logic [READ_W-1:0] READ_POS_CAP = READ_W'((64'd1 << 33) - 64'd1);

  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_X    = 8'h58;
  localparam logic [7:0] CHAR_STAR = 8'h2A;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NIL   = 2'd1,
    ST_ERR   = 2'd2
  } crp_status_e;

  typedef struct packed {
    logic [7:0]               cigar_byte;
    logic                     last;
    logic                     empty_req;
    logic [REF_POS_BITS-1:0]  align_pos;
    logic [READ_LEN_BITS-1:0] read_length;
  } crp_in_t;

  typedef struct packed {
    crp_status_e              status;
    logic [READ_LEN_BITS-1:0] read_index;
  } crp_out_t;

  typedef struct packed {
    logic     emit;
    crp_out_t word;
  } crp_res_t;

endpackage

FILE: hw/rtl/cigar_ref_to_read_position_top.sv
// Top level of the CIGAR reference-to-read position walker.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | target_ref_pos (31 bits)
//   in      | in        | in_valid_i/in_stall_o   | crp_in_t: one CIGAR byte
//   out     | out       | out_valid_o/out_stall_i | crp_out_t: status, read index
//
// One byte per cycle unless the output stalls; each byte and its result are registered.
// Throughput is set by the single walker stage, which updates all parse state per byte.
// Reset resets the parse state and sets the target to 1; configuration is always ready.
// A stalled result word holds; the input register still takes a word while the
// result register waits, and stalls only when both are full.
`include "assert_macros.svh"

module cigar_ref_to_read_position_top
  import crp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [REF_POS_BITS-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  crp_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output crp_out_t                out_data_o
);

  logic     advance;
  logic     fire;
  crp_in_t  word;
  crp_res_t res;
  logic     no_base;

  assign cfg_ready_o = 1'b1;
  assign no_base     = out_valid_o && (out_data_o.status != ST_FOUND);

  crp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .fire_o     (fire),
    .word_o     (word)
  );

  crp_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .word_i     (word),
    .res_o      (res)
  );

  crp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `CRP_ASSERT_IMPLIES(a_stall_full, in_stall_o, out_valid_o && out_stall_i, "stall, output free")
  `CRP_ASSERT_IMPLIES(a_index_zero, no_base, out_data_o.read_index == '0, "index without base")
  `CRP_ASSERT_IMPLIES(a_result_src, $rose(out_valid_o), $past(fire && res.emit), "no walker step")

endmodule

FILE: hw/rtl/crp_in_stage.sv
// Input register of the walker: holds one CIGAR word until the walker takes it.
module crp_in_stage
  import crp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  crp_in_t in_data_i,
  input  logic    advance_i,
  output logic    fire_o,
  output crp_in_t word_o
);

  logic    valid_q, valid_d;
  crp_in_t data_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign fire_o     = valid_q & advance_i;
  assign word_o     = data_q;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

FILE: hw/rtl/crp_walk.sv
// CIGAR parser and position tracker: one byte per cycle while fire_i is high, at most one result per byte.
module crp_walk
  import crp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [REF_POS_BITS-1:0] cfg_data_i,
  input  logic                    fire_i,
  input  crp_in_t                 word_i,
  output crp_res_t                res_o
);

  logic [REF_POS_BITS-1:0] target_q;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic                    hd_q, hd_d;
  logic                    first_q, first_d;
  logic [READ_W-1:0]       read_q, read_d;
  logic [REF_W-1:0]        ref_q, ref_d;
  logic                    decided_q, decided_d;

  logic [COUNT_BITS-1:0] cnt_eff;
  logic                  hd_eff;
  logic [READ_W-1:0]     read_eff, read_sum, read_new;
  logic [REF_W-1:0]      ref_eff, ref_add, target_ext;
  logic [CNT_EXT_W-1:0]  cnt_ext, cnt_next;
  logic [IDX_W-1:0]      idx;
  logic                  is_digit, overflow, adv_ref, adv_read, ref_hit, in_read;
  logic [7:0]            c;
  logic                  emit;
  crp_status_e           status;

  assign c          = word_i.cigar_byte;
  assign cnt_eff    = first_q ? '0 : cnt_q;
  assign hd_eff     = first_q ? 1'b0 : hd_q;
  assign read_eff   = first_q ? '1 : read_q;
  assign ref_eff    = first_q ? (REF_W'(word_i.align_pos) - REF_W'(1)) : ref_q;
  assign target_ext = REF_W'(target_q);

  assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  assign cnt_ext  = CNT_EXT_W'(cnt_eff);
  assign cnt_next = (cnt_ext << 3) + (cnt_ext << 1) + CNT_EXT_W'(c[3:0]);
  assign overflow = |cnt_next[CNT_EXT_W-1:COUNT_BITS];

  assign adv_ref  = (c == CHAR_M) || (c == CHAR_D) || (c == CHAR_N) ||
                    (c == CHAR_EQ) || (c == CHAR_X);
  assign adv_read = (c == CHAR_M) || (c == CHAR_I) || (c == CHAR_S) ||
                    (c == CHAR_EQ) || (c == CHAR_X);

  assign read_sum = read_eff + READ_W'(cnt_eff);
  assign read_new = (adv_read && !read_sum[READ_W-1] && (read_sum > READ_POS_CAP)) ?
                    READ_POS_CAP : (adv_read ? read_sum : read_eff);
  assign ref_add  = ref_eff + REF_W'(cnt_eff);
  assign ref_hit  = !ref_add[REF_W-1] && (ref_add >= target_ext);

  assign idx = {{(IDX_W-READ_W){read_new[READ_W-1]}}, read_new}
             - ({{(IDX_W-REF_W){ref_add[REF_W-1]}}, ref_add} - IDX_W'(target_q));
  assign in_read = !idx[IDX_W-1] && (idx < IDX_W'(word_i.read_length));

  always_comb begin
    emit      = 1'b0;
    status    = ST_NIL;
    cnt_d     = cnt_eff;
    hd_d      = hd_eff;
    first_d   = 1'b0;
    read_d    = read_eff;
    ref_d     = ref_eff;
    decided_d = decided_q;
    if (word_i.empty_req) begin
      emit = ~decided_q;
    end else if (!decided_q) begin
      if (first_q && (c == CHAR_STAR)) begin
        emit   = 1'b1;
        status = word_i.last ? ST_NIL : ST_ERR;
      end else if (is_digit) begin
        cnt_d = cnt_next[COUNT_BITS-1:0];
        hd_d  = 1'b1;
        if (overflow || word_i.last) begin
          emit   = 1'b1;
          status = ST_ERR;
        end
      end else if (!hd_eff) begin
        emit   = 1'b1;
        status = ST_ERR;
      end else begin
        cnt_d  = '0;
        hd_d   = 1'b0;
        read_d = read_new;
        if (adv_ref) begin
          ref_d = ref_add;
        end
        if (adv_ref && ref_hit) begin
          emit   = 1'b1;
          status = (adv_read && in_read) ? ST_FOUND : ST_NIL;
        end else if (word_i.last) begin
          emit   = 1'b1;
          status = ST_NIL;
        end
      end
      if (emit && !word_i.last) begin
        decided_d = 1'b1;
      end
    end
    if (word_i.empty_req || word_i.last) begin
      cnt_d     = '0;
      hd_d      = 1'b0;
      first_d   = 1'b1;
      read_d    = '1;
      ref_d     = '0;
      decided_d = 1'b0;
    end
  end

  always_comb begin
    res_o.emit            = emit;
    res_o.word.status     = status;
    res_o.word.read_index = (status == ST_FOUND) ? idx[READ_LEN_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= REF_POS_BITS'(1);
      cnt_q     <= '0;
      hd_q      <= 1'b0;
      first_q   <= 1'b1;
      read_q    <= '1;
      ref_q     <= '0;
      decided_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (fire_i) begin
        cnt_q     <= cnt_d;
        hd_q      <= hd_d;
        first_q   <= first_d;
        read_q    <= read_d;
        ref_q     <= ref_d;
        decided_q <= decided_d;
      end
    end
  end

endmodule

FILE: hw/rtl/crp_out_stage.sv
// Result register: holds one result word until the consumer takes it.
module crp_out_stage
  import crp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  crp_res_t res_i,
  output logic     advance_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output crp_out_t out_data_o
);

  logic     valid_q, valid_d;
  crp_out_t data_q;

  assign advance_o   = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = fire_i & res_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && fire_i && res_i.emit) begin
      data_q <= res_i.word;
    end
  end

endmodule
